// ----- rtl/core/first_fit_segment_allocator_macros.svh -----
// Assertion macros for the first-fit segment allocator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

// Property checked at every rising clock edge.
`define FFSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ffsa assertion failed");

// Implication checked in the same cycle.
`define FFSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ffsa implication failed");

`endif

// ----- rtl/core/ffsa_pkg.sv -----
// Package for the first-fit segment allocator: widths, codes, shared types.
// No dependencies.
`default_nettype none
package ffsa_pkg;

  localparam int ADDR_W       = 16;
  localparam int SIZE_W       = ADDR_W + 1;
  localparam int MAX_SEGMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = Q_PTR_W + 1;

  localparam logic [SIZE_W-1:0] POOL_CAP = SIZE_W'(1) << ADDR_W;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_EV,
    S_NXT_EV,
    S_GAP_RD,
    S_GAP_EV,
    S_RM_RD,
    S_RM_WR,
    S_INS_RD,
    S_INS_WR,
    S_DONE
  } bk_state_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] where;
    logic [SIZE_W-1:0] size;
  } cmd_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] fill;
  } fr_stat_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             busy;
  } bk_stat_t;

  // Gap [lo, hi) holds size units.
  function automatic logic fits(input logic [SIZE_W-1:0] lo,
                                input logic [SIZE_W-1:0] hi,
                                input logic [SIZE_W-1:0] size);
    fits = (hi > lo) && ((hi - lo) >= size);
  endfunction

  function automatic op_e decode_op(input logic [1:0] action);
    op_e op;
    case (action)
      2'd0:    op = OP_ALLOC;
      2'd1:    op = OP_FREE;
      2'd2:    op = OP_RESIZE;
      default: op = OP_NOP;
    endcase
    decode_op = op;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ffsa_ifs.sv -----
// Channel interfaces for the first-fit segment allocator.
// Depends on ffsa_pkg.
`default_nettype none
interface ffsa_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [ffsa_pkg::ADDR_W-1:0]  seg_address;
  logic [ffsa_pkg::SIZE_W-1:0]  req_size;
  modport source (output valid, action, seg_address, req_size, input ready);
  modport sink   (input valid, action, seg_address, req_size, output ready);
endinterface

interface ffsa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [ffsa_pkg::ADDR_W-1:0]  result_address;
  logic                         released;
  modport source (output valid, status, result_address, released, input ready);
  modport sink   (input valid, status, result_address, released, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ffsa_front.sv -----
// Front end: accepts request transactions, decodes the action, queues commands.
// Depends on ffsa_pkg and ffsa_ifs.
`default_nettype none
module ffsa_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  ffsa_req_if.sink             req,
  output ffsa_pkg::cmd_t       cmd_o,
  output logic                 cmd_valid_o,
  input  wire logic            cmd_pop_i,
  output ffsa_pkg::fr_stat_t   stat_o
);
  import ffsa_pkg::*;

  cmd_t               q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] fill_q, fill_d;
  logic               push, pop;

  assign req.ready   = (fill_q != Q_CNT_W'(Q_DEPTH));
  assign push        = req.valid && req.ready;
  assign cmd_valid_o = (fill_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem[rd_ptr_q];
  assign stat_o.fill = fill_q;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= '{op:    decode_op(req.action),
                           where: req.seg_address,
                           size:  req.req_size};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ffsa_back.sv -----
// Back end: segment table memories, scan/shift sequencer and response register.
// Depends on ffsa_pkg and ffsa_ifs.
`default_nettype none
module ffsa_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [ffsa_pkg::SIZE_W-1:0]  limit_i,
  input  wire ffsa_pkg::cmd_t               cmd_i,
  input  wire logic                         cmd_valid_i,
  output logic                              cmd_pop_o,
  ffsa_rsp_if.source                        rsp,
  output ffsa_pkg::bk_stat_t                stat_o
);
  import ffsa_pkg::*;

  logic [ADDR_W-1:0] start_mem [MAX_SEGMENTS];
  logic [ADDR_W-1:0] end_mem   [MAX_SEGMENTS];
  logic [ADDR_W-1:0] rd_s_q, rd_e_q;
  logic [CNT_W-1:0]  raddr;
  logic [CNT_W-1:0]  waddr;
  logic              we;
  logic [ADDR_W-1:0] wds, wde;

  bk_state_e         state_q, state_d;
  op_e               op_q, op_d;
  logic [ADDR_W-1:0] where_q, where_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  vi_q, vi_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  g_q, g_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic [SIZE_W-1:0] lo_q, lo_d;
  logic              skip_q, skip_d;
  logic              mv_q, mv_d;
  logic [ADDR_W-1:0] os_q, os_d;
  logic [ADDR_W-1:0] ns_q, ns_d;
  logic [ADDR_W-1:0] ne_q, ne_d;
  status_e           sts_q, sts_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              rel_q, rel_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_sts_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic              out_rel_q;

  logic [SIZE_W-1:0] lim_n;
  logic [SIZE_W-1:0] hi_gap;
  logic              gap_fit;
  logic [SIZE_W-1:0] new_end;
  logic [SIZE_W-1:0] rs_end;

  assign rsp.valid          = out_valid_q;
  assign rsp.status         = out_sts_q;
  assign rsp.result_address = out_addr_q;
  assign rsp.released       = out_rel_q;
  assign stat_o.count       = count_q;
  assign stat_o.busy        = (state_q != S_IDLE);

  always_comb begin
    lim_n   = ((pos_q + 1'b1) < count_q) ? {1'b0, rd_s_q} : limit_i;
    hi_gap  = (state_q == S_GAP_EV) ? {1'b0, rd_s_q} : limit_i;
    gap_fit = fits(lo_q, hi_gap, size_q);
    new_end = lo_q + size_q - 1'b1;
    rs_end  = {1'b0, os_q} + size_q - 1'b1;
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    where_d = where_q;
    size_d  = size_q;
    count_d = count_q;
    i_d     = i_q;
    vi_d    = vi_q;
    pos_d   = pos_q;
    g_d     = g_q;
    j_d     = j_q;
    lo_d    = lo_q;
    skip_d  = skip_q;
    mv_d    = mv_q;
    os_d    = os_q;
    ns_d    = ns_q;
    ne_d    = ne_q;
    sts_d   = sts_q;
    addr_d  = addr_q;
    rel_d   = rel_q;
    raddr   = '0;
    waddr   = '0;
    we      = 1'b0;
    wds     = rd_s_q;
    wde     = rd_e_q;
    cmd_pop_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          op_d    = cmd_i.op;
          where_d = cmd_i.where;
          size_d  = cmd_i.size;
          sts_d   = ST_OK;
          addr_d  = '0;
          rel_d   = 1'b0;
          skip_d  = 1'b0;
          mv_d    = 1'b0;
          i_d     = '0;
          vi_d    = '0;
          lo_d    = '0;
          case (cmd_i.op)
            OP_ALLOC: begin
              if (cmd_i.size > limit_i) begin
                sts_d   = ST_NOFIT;
                state_d = S_DONE;
              end else if (cmd_i.size == '0) begin
                state_d = S_DONE;
              end else begin
                state_d = S_GAP_RD;
              end
            end
            OP_FREE, OP_RESIZE: state_d = S_FIND_RD;
            default:            state_d = S_DONE;
          endcase
        end
      end

      S_FIND_RD: begin
        if (i_q == count_q) begin
          sts_d   = ST_NOTFOUND;
          state_d = S_DONE;
        end else begin
          raddr   = i_q;
          state_d = S_FIND_EV;
        end
      end

      S_FIND_EV: begin
        if (rd_s_q == where_q) begin
          pos_d = i_q;
          os_d  = rd_s_q;
          j_d   = i_q;
          if (op_q == OP_FREE) begin
            state_d = S_RM_RD;
          end else if (size_q == '0) begin
            rel_d   = 1'b1;
            state_d = S_RM_RD;
          end else begin
            // start of the following segment, if any
            raddr   = i_q + 1'b1;
            state_d = S_NXT_EV;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_FIND_RD;
        end
      end

      S_NXT_EV: begin
        if (fits({1'b0, os_q}, lim_n, size_q)) begin
          we      = 1'b1;
          waddr   = pos_q;
          wds     = os_q;
          wde     = rs_end[ADDR_W-1:0];
          addr_d  = os_q;
          state_d = S_DONE;
        end else if (size_q > limit_i) begin
          sts_d   = ST_NOFIT;
          state_d = S_DONE;
        end else begin
          // search as if the segment were already removed
          skip_d  = 1'b1;
          i_d     = '0;
          vi_d    = '0;
          lo_d    = '0;
          state_d = S_GAP_RD;
        end
      end

      S_GAP_RD, S_GAP_EV: begin
        if (state_q == S_GAP_RD && skip_q && i_q == pos_q) begin
          i_d = i_q + 1'b1;
        end else if (state_q == S_GAP_RD && i_q != count_q) begin
          raddr   = i_q;
          state_d = S_GAP_EV;
        end else if (gap_fit) begin
          ns_d   = lo_q[ADDR_W-1:0];
          ne_d   = new_end[ADDR_W-1:0];
          g_d    = vi_q;
          addr_d = lo_q[ADDR_W-1:0];
          if (skip_q) begin
            mv_d    = 1'b1;
            j_d     = pos_q;
            state_d = S_RM_RD;
          end else if (count_q >= CNT_W'(MAX_SEGMENTS)) begin
            sts_d   = ST_FULL;
            addr_d  = '0;
            state_d = S_DONE;
          end else begin
            j_d     = count_q;
            state_d = S_INS_RD;
          end
        end else if (state_q == S_GAP_EV) begin
          lo_d    = {1'b0, rd_e_q} + 1'b1;
          i_d     = i_q + 1'b1;
          vi_d    = vi_q + 1'b1;
          state_d = S_GAP_RD;
        end else begin
          sts_d   = ST_NOFIT;
          addr_d  = '0;
          state_d = S_DONE;
        end
      end

      S_RM_RD: begin
        if ((j_q + 1'b1) >= count_q) begin
          count_d = count_q - 1'b1;
          if (mv_q) begin
            j_d     = count_q - 1'b1;
            state_d = S_INS_RD;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          raddr   = j_q + 1'b1;
          state_d = S_RM_WR;
        end
      end

      S_RM_WR: begin
        we      = 1'b1;
        waddr   = j_q;
        j_d     = j_q + 1'b1;
        state_d = S_RM_RD;
      end

      S_INS_RD: begin
        if (j_q == g_q) begin
          we      = 1'b1;
          waddr   = g_q;
          wds     = ns_q;
          wde     = ne_q;
          count_d = count_q + 1'b1;
          state_d = S_DONE;
        end else begin
          raddr   = j_q - 1'b1;
          state_d = S_INS_WR;
        end
      end

      S_INS_WR: begin
        we      = 1'b1;
        waddr   = j_q;
        j_d     = j_q - 1'b1;
        state_d = S_INS_RD;
      end

      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase

    out_valid_d = (out_valid_q && !rsp.ready) || (state_q == S_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    where_q <= where_d;
    size_q  <= size_d;
    i_q     <= i_d;
    vi_q    <= vi_d;
    pos_q   <= pos_d;
    g_q     <= g_d;
    j_q     <= j_d;
    lo_q    <= lo_d;
    skip_q  <= skip_d;
    mv_q    <= mv_d;
    os_q    <= os_d;
    ns_q    <= ns_d;
    ne_q    <= ne_d;
    sts_q   <= sts_d;
    addr_q  <= addr_d;
    rel_q   <= rel_d;
    if (state_q == S_DONE) begin
      out_sts_q  <= sts_q;
      out_addr_q <= addr_q;
      out_rel_q  <= rel_q;
    end
  end

  // segment table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      start_mem[waddr[IDX_W-1:0]] <= wds;
      end_mem[waddr[IDX_W-1:0]]   <= wde;
    end
    rd_s_q <= start_mem[raddr[IDX_W-1:0]];
    rd_e_q <= end_mem[raddr[IDX_W-1:0]];
  end

endmodule
`default_nettype wire

// ----- rtl/core/first_fit_segment_allocator.sv -----
// Top level of the first-fit segment allocator: pool size register,
// front end queue and back end sequencer. Depends on ffsa_pkg, ffsa_ifs,
// ffsa_front, ffsa_back and first_fit_segment_allocator_macros.svh.
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+------------------------------------------
//  req     | in  | valid / ready  | action, seg_address, req_size
//  rsp     | out | valid / ready  | status, result_address, released
//  cfg     | in  | cfg_we_i       | cfg_wdata_i (pool_size)
//
//  Per transaction the sequencer scans the segment table entry by entry for
//  the start or the gap, then shifts table entries one by one on insert or
//  remove. The segment table has separate read and write ports.
//  Two requests queue ahead of the sequencer; a held response blocks the
//  next command start, not request acceptance. Reset clears the segment
//  count; the table needs no clearing pass.
`default_nettype none
module first_fit_segment_allocator (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ffsa_pkg::SIZE_W-1:0] cfg_wdata_i,
  ffsa_req_if.sink                         req,
  ffsa_rsp_if.source                       rsp
);
  import ffsa_pkg::*;

  logic [SIZE_W-1:0] pool_q;
  logic [SIZE_W-1:0] limit;
  cmd_t              cmd;
  logic              cmd_valid;
  logic              cmd_pop;
  fr_stat_t          fr_stat;
  bk_stat_t          bk_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= POOL_CAP;
    end else if (cfg_we_i) begin
      pool_q <= cfg_wdata_i;
    end
  end

  assign limit = (pool_q > POOL_CAP) ? POOL_CAP : pool_q;

  ffsa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .stat_o      (fr_stat)
  );

  ffsa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .rsp         (rsp),
    .stat_o      (bk_stat)
  );

`include "first_fit_segment_allocator_macros.svh"

  `FFSA_ASSERT(a_count_max, bk_stat.count <= CNT_W'(MAX_SEGMENTS))
  `FFSA_ASSERT(a_queue_max, fr_stat.fill <= Q_CNT_W'(Q_DEPTH))
  `FFSA_ASSERT_IMP(a_full_only_full, rsp.valid && rsp.status == ST_FULL,
                   bk_stat.count == CNT_W'(MAX_SEGMENTS))
  `FFSA_ASSERT_IMP(a_release_clean, rsp.valid && rsp.released,
                   rsp.status == ST_OK && rsp.result_address == '0)
  `FFSA_ASSERT_IMP(a_rsp_idle, rsp.valid, !bk_stat.busy)

endmodule
`default_nettype wire

// ----- tb/sv/ffsa_checker.sv -----
// Checker for the first-fit segment allocator: watches the request and
// response channels, predicts each response and compares it. Depends on ffsa_pkg, ffsa_ifs.
`timescale 1ns / 100ps
module ffsa_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ffsa_pkg::SIZE_W-1:0] cfg_wdata_i,
  ffsa_req_if                         req,
  ffsa_rsp_if                         rsp,
  output int                          fail_cnt_o,
  output int                          pending_o
);
  import ffsa_pkg::*;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] addr;
    logic              released;
  } answer_t;

  answer_t         answers_q[$];
  logic [SIZE_W-1:0] pool_q;
  int unsigned     seg_lo[MAX_SEGMENTS];
  int unsigned     seg_hi[MAX_SEGMENTS];
  int unsigned     nseg;

  assign pending_o = answers_q.size();

  function automatic int unsigned usable_units();
    return (pool_q > POOL_CAP) ? int'(POOL_CAP) : int'(pool_q);
  endfunction

  function automatic bit first_gap(int unsigned size, output int unsigned pos,
                                   output int unsigned addr);
    int unsigned lo, hi;
    for (int unsigned i = 0; i <= nseg; i++) begin
      lo = (i == 0) ? 0 : seg_hi[i-1] + 1;
      hi = (i < nseg) ? seg_lo[i] : usable_units();
      if (hi > lo && hi - lo >= size) begin
        pos = i;
        addr = lo;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void insert_seg(int unsigned pos, int unsigned lo, int unsigned hi);
    for (int unsigned i = nseg; i > pos; i--) begin
      seg_lo[i] = seg_lo[i-1];
      seg_hi[i] = seg_hi[i-1];
    end
    seg_lo[pos] = lo;
    seg_hi[pos] = hi;
    nseg++;
  endfunction

  function automatic void remove_seg(int unsigned pos);
    for (int unsigned i = pos; i + 1 < nseg; i++) begin
      seg_lo[i] = seg_lo[i+1];
      seg_hi[i] = seg_hi[i+1];
    end
    nseg--;
  endfunction

  function automatic bit lookup_seg(int unsigned start, output int unsigned pos);
    for (int unsigned i = 0; i < nseg; i++) begin
      if (seg_lo[i] == start) begin
        pos = i;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic status_e place(int unsigned size, output int unsigned addr);
    int unsigned pos;
    addr = 0;
    if (size > usable_units()) return ST_NOFIT;
    if (size == 0) return ST_OK;
    if (!first_gap(size, pos, addr)) begin
      addr = 0;
      return ST_NOFIT;
    end
    if (nseg >= MAX_SEGMENTS) begin
      addr = 0;
      return ST_FULL;
    end
    insert_seg(pos, addr, addr + size - 1);
    return ST_OK;
  endfunction

  function automatic answer_t book(op_e op, int unsigned where, int unsigned size);
    answer_t a;
    int unsigned pos, addr, lo, hi, lim;
    status_e st;
    a = '{status: ST_OK, addr: '0, released: 1'b0};
    addr = 0;
    case (op)
      OP_ALLOC: begin
        a.status = place(size, addr);
      end
      OP_FREE: begin
        if (lookup_seg(where, pos)) remove_seg(pos);
        else a.status = ST_NOTFOUND;
      end
      OP_RESIZE: begin
        if (!lookup_seg(where, pos)) begin
          a.status = ST_NOTFOUND;
        end else if (size == 0) begin
          remove_seg(pos);
          a.released = 1'b1;
        end else begin
          lo = seg_lo[pos];
          hi = seg_hi[pos];
          lim = (pos + 1 < nseg) ? seg_lo[pos+1] : usable_units();
          if (lim > lo && lim - lo >= size) begin
            seg_hi[pos] = lo + size - 1;
            addr = lo;
          end else begin
            remove_seg(pos);
            st = place(size, addr);
            if (st != ST_OK) begin
              // move failed: put the segment back where it was
              insert_seg(pos, lo, hi);
              a.status = ST_NOFIT;
              addr = 0;
            end
          end
        end
      end
      default: ;
    endcase
    a.addr = addr[ADDR_W-1:0];
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_a;
    if (!rst_ni) begin
      pool_q <= POOL_CAP;
      nseg = 0;
      answers_q.delete();
      fail_cnt_o <= 0;
    end else begin
      if (cfg_we_i) pool_q <= cfg_wdata_i;
      if (req.valid && req.ready)
        answers_q.push_back(book(decode_op(req.action), req.seg_address, req.req_size));
      if (rsp.valid && rsp.ready) begin
        if (answers_q.size() == 0) begin
          $error("response with no request pending");
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_a = answers_q.pop_front();
          if (rsp.status != exp_a.status || rsp.result_address != exp_a.addr ||
              rsp.released != exp_a.released)
            fail_cnt_o <= fail_cnt_o + 1;
          if (rsp.status != exp_a.status)
            $error("status: expected %0d, got %0d", exp_a.status, rsp.status);
          if (rsp.result_address != exp_a.addr)
            $error("result_address: expected %0d, got %0d", exp_a.addr,
                   rsp.result_address);
          if (rsp.released != exp_a.released)
            $error("released: expected %0d, got %0d", exp_a.released, rsp.released);
        end
      end
    end
  end
endmodule

// ----- tb/sv/testbench.sv -----
// Top of the allocator testbench: clock, reset, stimulus and verdict.
// Depends on ffsa_pkg, ffsa_ifs, ffsa_checker and first_fit_segment_allocator.
`timescale 1ns / 100ps
module testbench;
  import ffsa_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata_i = '0;
  int                fail_cnt, pending;
  int                cycle_cnt = 0;
  int                idle_pct = 33;
  bit                hold_off = 1'b0;
  int unsigned       known_starts[$];

  ffsa_req_if req ();
  ffsa_rsp_if rsp ();

  first_fit_segment_allocator i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req(req), .rsp(rsp)
  );

  ffsa_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req(req), .rsp(rsp), .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // track result addresses so frees and resizes often hit real segments
  always @(posedge clk_i) begin
    if (rsp.valid && rsp.ready && rsp.status == ST_OK && rsp.result_address != 0)
      known_starts.push_back(rsp.result_address);
    if (known_starts.size() > 40) void'(known_starts.pop_front());
  end

  // response side: random stalls, plus one long hold-off
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // valid stays high after a transaction; callers drop it when the stream stops
  task automatic send(op_e op, logic [ADDR_W-1:0] where, logic [SIZE_W-1:0] size);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid <= 1'b1;
    req.action <= op;
    req.seg_address <= where;
    req.req_size <= size;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_pool(logic [SIZE_W-1:0] value);
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned r;
    logic [ADDR_W-1:0] where;
    logic [SIZE_W-1:0] size;
    r = $urandom_range(99);
    if (known_starts.size() != 0 && $urandom_range(3) != 0)
      where = ADDR_W'(known_starts[$urandom_range(known_starts.size() - 1)]);
    else if ($urandom_range(1)) where = '0;
    else where = ADDR_W'($urandom);
    case ($urandom_range(9))
      0:       size = SIZE_W'($urandom);
      1:       size = '0;
      2:       size = SIZE_W'($urandom_range(65536, 30000));
      default: size = SIZE_W'($urandom_range(2000, 1));
    endcase
    if (r < 45) send(OP_ALLOC, ADDR_W'($urandom), size);
    else if (r < 70) send(OP_FREE, where, size);
    else if (r < 97) send(OP_RESIZE, where, size);
    else send(OP_NOP, ADDR_W'($urandom), SIZE_W'($urandom));
  endtask

  initial begin
    req.valid = 1'b0;
    req.action = OP_NOP;
    req.seg_address = '0;
    req.req_size = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, every operation, each special case
    send(OP_ALLOC, 16'hFFFF, 0);
    send(OP_ALLOC, 0, 17'h10001);
    send(OP_ALLOC, 0, 17'h10000);
    send(OP_ALLOC, 0, 1);
    send(OP_FREE, 0, 0);
    send(OP_ALLOC, 0, 100);
    send(OP_ALLOC, 0, 50);
    send(OP_RESIZE, 0, 120);
    send(OP_RESIZE, 100, 10);
    send(OP_RESIZE, 0, 40000);
    send(OP_RESIZE, 0, 65536);
    send(OP_RESIZE, 16'hFFFF, 0);
    send(OP_FREE, 16'hFFFF, 17'h1FFFF);
    send(OP_RESIZE, 100, 0);
    send(OP_NOP, 16'hFFFF, 17'h1FFFF);
    send(OP_FREE, 0, 0);
    for (int i = 0; i < 66; i++) send(OP_ALLOC, 0, 1);
    write_pool(10);
    send(OP_ALLOC, 0, 5);
    send(OP_RESIZE, 0, 0);
    send(OP_ALLOC, 0, 1);
    write_pool(1);
    send(OP_ALLOC, 0, 2);

    // long hold-off on responses while requests keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) random_item();
    join

    write_pool(17'h1FFFF);
    for (int i = 0; i < 64; i++) send(OP_FREE, ADDR_W'(i), 0);
    for (int i = 0; i < 700; i++) random_item();
    write_pool(17'h10000);
    idle_pct = 0;
    for (int i = 0; i < 300; i++) random_item();
    idle_pct = 33;
    write_pool(3000);
    for (int i = 0; i < 400; i++) random_item();
    write_pool(SIZE_W'($urandom_range(65536, 1)));
    for (int i = 0; i < 400; i++) random_item();

    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ffsa_pkg.sv
rtl/core/ffsa_ifs.sv
rtl/core/ffsa_front.sv
rtl/core/ffsa_back.sv
rtl/core/first_fit_segment_allocator.sv
tb/sv/ffsa_checker.sv
tb/sv/testbench.sv
